// ----- sv/ecep_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ecep_pkg;

	localparam int unsigned FieldBits = 16;
	localparam int unsigned WideBits  = 32;

	typedef struct packed {
		logic                 arrivals_done;
		logic [FieldBits-1:0] batch_count;
		logic [FieldBits-1:0] shelf_life;
	} item_t;

	typedef struct packed {
		logic                consumed;
		logic [WideBits-1:0] total_consumed;
		logic                pool_empty;
		logic                dropped_full;
	} result_t;

	typedef struct packed {
		logic accept;
		logic pop;
		logic eat;
	} cmd_t;

	typedef struct packed {
		logic head_expired;
		logic nonempty;
	} status_t;

endpackage

`default_nettype wire

// ----- sv/ecep_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ecep_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	output logic                  result_valid,
	input  wire logic             result_stall,
	input  wire ecep_pkg::status_t status,
	output ecep_pkg::cmd_t        cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;
	logic   slot_free;

	assign slot_free    = !result_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_WORK;
				end
			end
			ST_WORK: begin
				if (status.head_expired) begin
					cmd.pop = 1'b1;
				end else if (slot_free) begin
					cmd.eat = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.eat) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/ecep_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ecep_datapath #(
	parameter int unsigned POOL_ENTRIES = 64,
	parameter int unsigned COUNT_BITS   = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ecep_pkg::item_t  item,
	input  wire ecep_pkg::cmd_t   cmd,
	output ecep_pkg::status_t     status,
	output ecep_pkg::result_t     result
);

	localparam int unsigned OccBits = $clog2(POOL_ENTRIES + 1);
	localparam int unsigned WB      = ecep_pkg::WideBits;
	localparam int unsigned FB      = ecep_pkg::FieldBits;

	logic [WB-1:0]         exp_q [POOL_ENTRIES];
	logic [COUNT_BITS-1:0] rem_q [POOL_ENTRIES];
	logic [OccBits-1:0]    occ_q;
	logic [WB-1:0]         day_q;
	logic [WB-1:0]         total_q;
	logic                  dropped_q;
	ecep_pkg::result_t     result_q;

	logic [WB:0]           exp_sum;
	logic [WB-1:0]         new_exp;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  has_batch;
	logic                  full;
	logic                  do_ins;
	logic                  nonempty;
	logic                  head_last;
	logic                  pop_now;
	logic                  dec_head;
	logic [POOL_ENTRIES-1:0] gt;
	logic [OccBits-1:0]    occ_after_eat;

	assign exp_sum  = {1'b0, day_q} + {{(WB + 1 - FB){1'b0}}, item.shelf_life};
	assign new_exp  = exp_sum[WB] ? '1 : exp_sum[WB-1:0];

	generate
		if (COUNT_BITS >= FB) begin : g_cnt_wide
			assign new_cnt = COUNT_BITS'(item.batch_count);
		end else begin : g_cnt_sat
			assign new_cnt = (|item.batch_count[FB-1:COUNT_BITS]) ?
				'1 : item.batch_count[COUNT_BITS-1:0];
		end
	endgenerate

	assign has_batch = !item.arrivals_done && (item.batch_count != '0);
	assign full      = (occ_q == OccBits'(POOL_ENTRIES));
	assign do_ins    = cmd.accept && has_batch && !full;
	assign nonempty  = (occ_q != '0);
	assign head_last = (rem_q[0] <= COUNT_BITS'(1));
	assign pop_now   = cmd.pop || (cmd.eat && nonempty && head_last);
	assign dec_head  = cmd.eat && nonempty && !head_last;

	assign status.nonempty     = nonempty;
	assign status.head_expired = nonempty && (exp_q[0] <= day_q);

	assign occ_after_eat = (nonempty && head_last) ? occ_q - OccBits'(1) : occ_q;

	for (genvar k = 0; k < POOL_ENTRIES; k++) begin : g_cell
		logic [WB-1:0]         up_exp;
		logic [COUNT_BITS-1:0] up_rem;
		logic                  up_gt;
		logic [WB-1:0]         dn_exp;
		logic [COUNT_BITS-1:0] dn_rem;
		logic                  at_end;

		assign gt[k]  = (OccBits'(k) < occ_q) && (exp_q[k] > new_exp);
		assign at_end = (OccBits'(k) == occ_q);

		if (k == 0) begin : g_first
			assign up_gt  = 1'b0;
			assign up_exp = '0;
			assign up_rem = '0;
		end else begin : g_inner
			assign up_gt  = gt[k-1];
			assign up_exp = exp_q[k-1];
			assign up_rem = rem_q[k-1];
		end

		if (k == POOL_ENTRIES - 1) begin : g_last
			assign dn_exp = '0;
			assign dn_rem = '0;
		end else begin : g_body
			assign dn_exp = exp_q[k+1];
			assign dn_rem = rem_q[k+1];
		end

		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (up_gt) begin
					exp_q[k] <= up_exp;
					rem_q[k] <= up_rem;
				end else if (gt[k] || at_end) begin
					exp_q[k] <= new_exp;
					rem_q[k] <= new_cnt;
				end
			end else if (pop_now) begin
				exp_q[k] <= dn_exp;
				rem_q[k] <= dn_rem;
			end else if (dec_head && (k == 0)) begin
				rem_q[k] <= rem_q[k] - COUNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			day_q   <= '0;
			total_q <= '0;
		end else begin
			if (do_ins) begin
				occ_q <= occ_q + OccBits'(1);
			end else if (pop_now) begin
				occ_q <= occ_q - OccBits'(1);
			end
			if (cmd.eat) begin
				if (day_q != '1) begin
					day_q <= day_q + WB'(1);
				end
				if (nonempty && (total_q != '1)) begin
					total_q <= total_q + WB'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dropped_q <= has_batch && full;
		end
		if (cmd.eat) begin
			result_q.consumed       <= nonempty;
			result_q.total_consumed <= (nonempty && (total_q != '1)) ?
				total_q + WB'(1) : total_q;
			result_q.pool_empty     <= (occ_after_eat == '0);
			result_q.dropped_full   <= dropped_q;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

// ----- sv/expiring_credit_edf_pool_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted transaction moves the control from idle to work. There each expired batch is
// dropped from the head of the sorted cell chain (one drop per cycle), then a unit is eaten
// and its result is registered once the result slot is free; no new transaction is taken until then.
// Reset clears the batch count, the day, the running total and all control state;
// the batch cells hold no defined value until written.

module expiring_credit_edf_pool_core #(
	parameter int unsigned POOL_ENTRIES = 64,
	parameter int unsigned COUNT_BITS   = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire ecep_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output ecep_pkg::result_t      result
);

	ecep_pkg::cmd_t    cmd;
	ecep_pkg::status_t status;

	ecep_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	ecep_datapath #(
		.POOL_ENTRIES (POOL_ENTRIES),
		.COUNT_BITS   (COUNT_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> status.nonempty)
		else $error("Pop issued on an empty pool.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> item_stall)
		else $error("Block took no time to work on an accepted transaction.");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eat |=> result_valid)
		else $error("Result register not loaded after a finished tick.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.eat && !status.nonempty) |=> (result.pool_empty && !result.consumed))
		else $error("Empty pool reported a consumed unit.");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned POOL_ENTRIES  = 64;
	localparam int unsigned COUNT_BITS    = 16;
	localparam int unsigned RESET_CYCLES  = 11;
	localparam int unsigned ITEM_TARGET   = 1050;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned QUIET_LIMIT   = 4000;
	localparam int unsigned SETTLE_CYCLES = 2 * (POOL_ENTRIES + 2);
	localparam int          DIRECTED_COUNT = 20;

	typedef struct packed {
		ecep_pkg::item_t   stim;
		logic              known;
		ecep_pkg::result_t want;
	} day_row_t;

	typedef enum {
		PATTERN_CHURN,
		PATTERN_FILL,
		PATTERN_DRAIN,
		PATTERN_LONG_LIFE,
		PATTERN_NOISE
	} day_pattern_t;

	// Rows with a known result start from an empty pool on day zero.
	localparam day_row_t DIRECTED_DAYS [DIRECTED_COUNT] = '{
		'{'{1'b1, 16'hFFFF, 16'hFFFF}, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0}},
		'{'{1'b0, 16'd5, 16'd0}, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0}},
		'{'{1'b0, 16'd0, 16'hFFFF}, 1'b1, '{1'b0, 32'd0, 1'b1, 1'b0}},
		'{'{1'b0, 16'd1, 16'd1}, 1'b1, '{1'b1, 32'd1, 1'b1, 1'b0}},
		'{'{1'b0, 16'hFFFF, 16'hFFFF}, 1'b1, '{1'b1, 32'd2, 1'b0, 1'b0}},
		'{'{1'b0, 16'd3, 16'd2}, 1'b0, '0},
		'{'{1'b1, 16'd0, 16'd0}, 1'b0, '0},
		'{'{1'b1, 16'd0, 16'd0}, 1'b0, '0},
		'{'{1'b0, 16'd2, 16'd5}, 1'b0, '0},
		'{'{1'b0, 16'd4, 16'd4}, 1'b0, '0},
		'{'{1'b0, 16'd1, 16'd0}, 1'b0, '0},
		'{'{1'b0, 16'h8000, 16'h8000}, 1'b0, '0},
		'{'{1'b0, 16'h7FFF, 16'h7FFF}, 1'b0, '0},
		'{'{1'b0, 16'hAAAA, 16'h5555}, 1'b0, '0},
		'{'{1'b0, 16'h5555, 16'hAAAA}, 1'b0, '0},
		'{'{1'b1, 16'd1, 16'd1}, 1'b0, '0},
		'{'{1'b0, 16'd1, 16'd3}, 1'b0, '0},
		'{'{1'b1, 16'hFFFF, 16'd0}, 1'b0, '0},
		'{'{1'b0, 16'd1, 16'd1}, 1'b0, '0},
		'{'{1'b0, 16'd2, 16'd0}, 1'b0, '0}
	};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	ecep_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	ecep_pkg::result_t result;

	logic [31:0]           pool_expiry [POOL_ENTRIES];
	logic [COUNT_BITS-1:0] pool_left   [POOL_ENTRIES];
	int unsigned           pool_fill   = 0;
	logic [31:0]           today       = '0;
	logic [31:0]           eaten       = '0;

	day_row_t          offered_rows [$];
	ecep_pkg::result_t owed_reports [$];
	int unsigned days_offered = 0;
	int unsigned days_taken   = 0;
	int unsigned burst_left   = 0;
	int unsigned mismatches   = 0;

	expiring_credit_edf_pool_core #(
		.POOL_ENTRIES(POOL_ENTRIES),
		.COUNT_BITS  (COUNT_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #10 clk = ~clk;

	function automatic void remove_head();
		for (int k = 0; k + 1 < int'(pool_fill); k++) begin
			pool_expiry[k] = pool_expiry[k+1];
			pool_left[k]   = pool_left[k+1];
		end
		if (pool_fill > 0) begin
			pool_fill--;
		end
	endfunction

	function automatic ecep_pkg::result_t predict_day(input ecep_pkg::item_t day);
		ecep_pkg::result_t report;
		logic [32:0]       due;
		int unsigned       pos;
		report = '0;
		if (!day.arrivals_done && day.batch_count != '0) begin
			if (pool_fill >= POOL_ENTRIES) begin
				report.dropped_full = 1'b1;
			end else begin
				due = {1'b0, today} + {17'd0, day.shelf_life};
				if (due[32]) begin
					due = {1'b0, 32'hFFFF_FFFF};
				end
				pos = 0;
				while (pos < pool_fill && pool_expiry[pos] <= due[31:0]) begin
					pos++;
				end
				for (int k = int'(pool_fill); k > int'(pos); k--) begin
					pool_expiry[k] = pool_expiry[k-1];
					pool_left[k]   = pool_left[k-1];
				end
				pool_expiry[pos] = due[31:0];
				pool_left[pos]   = day.batch_count;
				pool_fill++;
			end
		end
		while (pool_fill > 0 && pool_expiry[0] <= today) begin
			remove_head();
		end
		if (pool_fill > 0) begin
			report.consumed = 1'b1;
			if (eaten != 32'hFFFF_FFFF) begin
				eaten++;
			end
			if (pool_left[0] != '0) begin
				pool_left[0]--;
			end
			if (pool_left[0] == '0) begin
				remove_head();
			end
		end
		if (today != 32'hFFFF_FFFF) begin
			today++;
		end
		report.total_consumed = eaten;
		report.pool_empty     = (pool_fill == 0);
		return report;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// The sender works in bursts; before most bursts it lowers valid for a random gap.
	task automatic offer(input day_row_t row);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		offered_rows.push_back(row);
		days_offered++;
		item       <= row.stim;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	always @(posedge clk) begin : watch_transactions
		day_row_t          row;
		ecep_pkg::result_t guess;
		ecep_pkg::result_t want;
		int unsigned       quiet;
		logic              moved;
		if (arst_n) begin
			moved = 1'b0;
			if (item_valid && !item_stall) begin
				moved = 1'b1;
				row = offered_rows.pop_front();
				guess = predict_day(item);
				owed_reports.push_back(row.known ? row.want : guess);
				days_taken++;
			end
			if (result_valid && !result_stall) begin
				moved = 1'b1;
				if (owed_reports.size() == 0) begin
					$error("result transaction arrived with none outstanding");
					mismatches++;
				end else begin
					want = owed_reports.pop_front();
					compare_field("consumed", 32'(want.consumed), 32'(result.consumed));
					compare_field("total_consumed", want.total_consumed,
						result.total_consumed);
					compare_field("pool_empty", 32'(want.pool_empty), 32'(result.pool_empty));
					compare_field("dropped_full", 32'(want.dropped_full),
						32'(result.dropped_full));
				end
			end
			quiet = moved ? 0 : quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top: FAIL");
				$finish;
			end
		end
	end

	initial begin : result_backpressure
		int unsigned odds;
		int unsigned span;
		bit          held;
		held = 1'b0;
		forever begin
			if (!held && days_taken >= 400) begin
				held = 1'b1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					result_stall <= 1'b1;
				end
			end else begin
				odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
				span = $urandom_range(20, 200);
				repeat (span) begin
					@(posedge clk);
					result_stall <= ($urandom_range(0, 9) < odds);
				end
			end
		end
	end

	initial begin : drive_days
		day_row_t     row;
		day_pattern_t pattern;
		int unsigned  pick;
		int unsigned  span;
		bit           paused;
		paused = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			offer(DIRECTED_DAYS[i]);
		end
		while (days_offered < ITEM_TARGET) begin
			if (!paused && days_offered >= ITEM_TARGET * 2 / 3) begin
				paused = 1'b1;
				item_valid <= 1'b0;
				@(posedge clk);
				while (owed_reports.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 9);
			pattern = (pick < 3) ? PATTERN_CHURN :
				(pick < 5) ? PATTERN_FILL :
				(pick < 7) ? PATTERN_DRAIN :
				(pick < 8) ? PATTERN_LONG_LIFE : PATTERN_NOISE;
			case (pattern)
				PATTERN_CHURN:     span = $urandom_range(15, 40);
				PATTERN_FILL:      span = $urandom_range(70, 90);
				PATTERN_DRAIN:     span = $urandom_range(5, 40);
				PATTERN_LONG_LIFE: span = $urandom_range(2, 6);
				default:           span = $urandom_range(5, 20);
			endcase
			repeat (span) begin
				row = '0;
				case (pattern)
					PATTERN_CHURN: begin
						row.stim.arrivals_done = ($urandom_range(0, 3) == 0);
						row.stim.batch_count   = 16'($urandom_range(0, 3));
						row.stim.shelf_life    = 16'($urandom_range(0, 12));
					end
					PATTERN_FILL: begin
						row.stim.batch_count = 16'($urandom_range(1, 65535));
						row.stim.shelf_life  = 16'($urandom_range(40, 160));
					end
					PATTERN_DRAIN: begin
						row.stim.arrivals_done = 1'b1;
						row.stim.batch_count   = 16'($urandom());
						row.stim.shelf_life    = 16'($urandom());
					end
					PATTERN_LONG_LIFE: begin
						row.stim.batch_count = 16'($urandom_range(1, 3));
						row.stim.shelf_life  = 16'($urandom());
					end
					default: begin
						row.stim.arrivals_done = 1'($urandom_range(0, 1));
						row.stim.batch_count   = 16'($urandom_range(0, 8));
						row.stim.shelf_life    = 16'($urandom_range(0, 400));
					end
				endcase
				offer(row);
			end
		end
		item_valid <= 1'b0;
		@(posedge clk);
		while (owed_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
